// ===== design/wspc_pkg.sv =====
package wspc_pkg;

  localparam int MAX_PATTERN = 8;

  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W   = (LEN_W > 4) ? LEN_W : 4;
  localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam int PAT_W   = 64;
  localparam int PLEN_W  = 4;
  localparam int LINE_W  = 20;
  localparam int COL_W   = 16;
  localparam int COUNT_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(1);

  typedef logic [MAX_PATTERN-1:0][7:0]        chars_t;
  typedef logic [MAX_PATTERN-1:0][LINE_W-1:0] lines_t;
  typedef logic [MAX_PATTERN-1:0][COL_W-1:0]  cols_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } match_t;

endpackage

// ===== design/whitespace_skipping_pattern_counter.sv =====
// Whitespace-insensitive pattern counter.
// Feed a text file one byte per word on the item channel (data_byte, with
// file_start set on the first byte of each file to clear line, column,
// window and count). Spaces, tabs and newlines are skipped when matching,
// and every overlapping occurrence of the pattern gives one word on the hit
// channel: 1-based line and column of the first character and the running
// hit count, all saturating.
// The pattern is set on the cfg channel (index 0: pattern bytes, first in
// the lowest byte; index 1: length) while no bytes are in flight; cfg_ready
// is always high.
// Path: a byte enters the input register; window update and compare then load
// the hit register, which holds the hit word until it is taken.
// Throughput: one byte per cycle while no hit word stalls, set by the
// combinational window shift and parallel compare. While a hit word waits on
// hit_ready, bytes that do not complete a match keep flowing; a byte that
// completes one holds in the input register until the hit register frees.
// Reset clears the window, sets line 1, column 0, count 0, pattern zero and
// length 1.
module whitespace_skipping_pattern_counter import wspc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [7:0]           data_byte,
  input  logic                 file_start,
  output logic                 hit_valid,
  input  logic                 hit_ready,
  output logic [LINE_W-1:0]    hit_line,
  output logic [COL_W-1:0]     hit_column,
  output logic [COUNT_W-1:0]   hit_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  logic [PAT_W-1:0]   pattern_chars;
  logic [PLEN_W-1:0]  pattern_length;

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_start;
  logic               s1_go;

  chars_t             win_chars, win_chars_next;
  lines_t             win_lines, win_lines_next;
  cols_t              win_cols, win_cols_next;
  logic [LEN_W-1:0]   fill, fill_next;
  logic [LINE_W-1:0]  line, line_next, base_line;
  logic [COL_W-1:0]   col, col_next, base_col, col_inc;
  logic [COUNT_W-1:0] hits, hits_next, base_hits;
  logic [LEN_W-1:0]   base_fill;
  logic               is_nl, is_char, hit_now, hit_free;
  match_t             m;

  assign cfg_ready  = 1'b1;
  assign hit_free   = !hit_valid || hit_ready;
  assign s1_go      = s1_valid && (hit_free || !hit_now);
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= PLEN_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_CHARS:  pattern_chars  <= cfg_data;
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_byte  <= data_byte;
      s1_start <= file_start;
    end
  end

  always_comb begin
    base_line = s1_start ? LINE_W'(1) : line;
    base_col  = s1_start ? '0 : col;
    base_fill = s1_start ? '0 : fill;
    base_hits = s1_start ? '0 : hits;

    col_inc = (base_col != COL_MAX) ? base_col + COL_W'(1) : base_col;
    is_nl   = (s1_byte == CHAR_NL);
    is_char = !is_nl && (s1_byte != CHAR_SP) && (s1_byte != CHAR_TAB);

    line_next      = base_line;
    col_next       = col_inc;
    fill_next      = base_fill;
    win_chars_next = win_chars;
    win_lines_next = win_lines;
    win_cols_next  = win_cols;

    if (is_nl) begin
      col_next = '0;
      if (base_line != LINE_MAX) begin
        line_next = base_line + LINE_W'(1);
      end
    end else if (is_char) begin
      // shift the new character in at entry 0
      for (int k = MAX_PATTERN - 1; k > 0; k--) begin
        win_chars_next[k] = win_chars[k-1];
        win_lines_next[k] = win_lines[k-1];
        win_cols_next[k]  = win_cols[k-1];
      end
      win_chars_next[0] = s1_byte;
      win_lines_next[0] = base_line;
      win_cols_next[0]  = col_inc;
      if (base_fill != LEN_W'(MAX_PATTERN)) begin
        fill_next = base_fill + LEN_W'(1);
      end
    end
  end

  wspc_matcher u_matcher (
    .win_chars      (win_chars_next),
    .fill           (fill_next),
    .pattern_chars  (pattern_chars),
    .pattern_length (pattern_length),
    .result         (m)
  );

  assign hit_now = is_char && m.hit;

  always_comb begin
    hits_next = base_hits;
    if (hit_now && (base_hits != COUNT_MAX)) begin
      hits_next = base_hits + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      line <= LINE_W'(1);
      col  <= '0;
      hits <= '0;
    end else if (s1_go) begin
      fill <= fill_next;
      line <= line_next;
      col  <= col_next;
      hits <= hits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_chars <= win_chars_next;
      win_lines <= win_lines_next;
      win_cols  <= win_cols_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (s1_go && hit_now) begin
      hit_valid <= 1'b1;
    end else if (hit_ready) begin
      hit_valid <= 1'b0;
    end
  end

  // hold the hit word until taken
  always_ff @(posedge clk) begin
    if (s1_go && hit_now) begin
      hit_line   <= win_lines_next[m.idx];
      hit_column <= win_cols_next[m.idx];
      hit_count  <= hits_next;
    end
  end

  a_hit_loads: assert property (@(posedge clk) disable iff (rst)
    s1_go && hit_now |=> hit_valid && (hit_count == $past(hits_next)))
    else $error("hit word not loaded");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    s1_go && hit_now && !s1_start && (hits != COUNT_MAX) |=> hits == $past(hits) + COUNT_W'(1))
    else $error("hit count did not advance");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(MAX_PATTERN))
    else $error("window fill beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    hit_valid && !hit_ready |-> !(s1_go && hit_now))
    else $error("pending hit word overwritten");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> (hit_count != '0) && (hit_line != '0) && (hit_column != '0))
    else $error("hit word holds a zero field");

endmodule

// ===== design/wspc_matcher.sv =====
module wspc_matcher import wspc_pkg::*; (
  input  chars_t             win_chars,
  input  logic [LEN_W-1:0]   fill,
  input  logic [PAT_W-1:0]   pattern_chars,
  input  logic [PLEN_W-1:0]  pattern_length,
  output match_t             result
);

  chars_t                 pat;
  logic [LEN_W-1:0]       len;
  logic [IDX_W-1:0]       idx;
  logic [MAX_PATTERN-1:0] by_len;
  logic                   ok;

  always_comb begin
    // pattern bytes past the register read as zero
    pat = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < 8) begin
        pat[i] = pattern_chars[8*(i%8) +: 8];
      end
    end

    if (CMP_W'(pattern_length) > CMP_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = LEN_W'(pattern_length);
    end

    // one candidate per length: oldest window entry lines up with pattern byte 0
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      ok = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win_chars[l-1-i] != pat[i]) begin
          ok = 1'b0;
        end
      end
      by_len[l-1] = ok;
    end

    idx = IDX_W'(len - LEN_W'(1));
    result.idx = idx;
    result.hit = (len != '0) && (CMP_W'(fill) >= CMP_W'(len)) && by_len[idx];
  end

endmodule
